### rtl/ipv4_header_build_and_fragment_macros.svh
`ifndef IPV4_HEADER_BUILD_AND_FRAGMENT_MACROS_SVH
`define IPV4_HEADER_BUILD_AND_FRAGMENT_MACROS_SVH

// check outside reset
`define IHBF_ASSERT(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// check on every edge, reset included
`define IHBF_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) (expr)) else $error(msg);

`endif

### rtl/ihbf_pkg.sv
package ihbf_pkg;

   localparam int QDEPTH    = 4;
   localparam int QIDX_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);
   localparam int HDR_BYTES = 20;
   localparam int HDR_WORDS = 10;
   localparam int IDX_W     = 5;
   localparam int WSEL_W    = 4;

   localparam logic [7:0]       VERSION_IHL = 8'h45;
   localparam logic [15:0]      MF_BIT      = 16'h2000;
   localparam logic [IDX_W-1:0] CSUM_HI     = 5'd10;
   localparam logic [IDX_W-1:0] CSUM_LO     = 5'd11;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ADDR      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPLIT_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAGMENT_PAYLOAD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_TO_LIVE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_PROTOCOL   = 3'd4;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] payload_length;
      logic [31:0] dest_addr;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       datagram_end;
      logic       run_end;
   } rsp_type;

   typedef struct packed {
      logic [31:0] source_addr;
      logic [15:0] split_threshold;
      logic [15:0] fragment_payload;
      logic [7:0]  time_to_live;
      logic [7:0]  upper_protocol;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        hdr;
      logic [15:0] total_len;
      logic [15:0] id;
      logic [15:0] flags_off;
      logic [31:0] dest;
      logic        pend;
      logic        dend;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef logic [HDR_BYTES-1:0][7:0] hdr_bytes_type;
   typedef logic [HDR_WORDS-1:0][15:0] hdr_words_type;

   // header with the checksum field zero, first byte in the top element
   function automatic hdr_bytes_type hdr_build(job_type j, cfg_type c);
      return {VERSION_IHL, 8'h00, j.total_len, j.id, j.flags_off,
              c.time_to_live, c.upper_protocol, 16'h0000,
              c.source_addr, j.dest};
   endfunction

endpackage

### rtl/ipv4_header_build_and_fragment.sv
// channel   direction  handshake          payload
// req       in         req_push/req_full  req_data (byte, length, destination)
// rsp       out        rsp_pop/rsp_empty  rsp_data (byte, packet/datagram/run end)
// csr       in         csr_write          csr_index, csr_data
//
// One payload byte enters per cycle, unless req_full is high, into a four-entry job
// queue; the back end sends one packet byte per cycle unless held, so a fragment's
// first payload byte follows 20 header bytes; its other payload bytes have none.
// Reset is synchronous; no clearing pass.
// req_full rises when the job queue holds four jobs; rsp_pop low holds the back end while an output byte waits.

`include "ipv4_header_build_and_fragment_macros.svh"

module ipv4_header_build_and_fragment
   import ihbf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   cfg_type      cfg;
   job_type      front_job;
   job_type      q_data;
   q_status_type q_status;
   logic         accept;
   logic         q_pop;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   ihbf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ihbf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .accept (accept),
      .req    (req_data),
      .job    (front_job)
   );

   ihbf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_job),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   ihbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_status.empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   `IHBF_ASSERT(a_idle_after_reset, $past(reset) |-> rsp_empty, "output valid after reset")
   `IHBF_ASSERT(a_queue_sane, !(q_status.full && q_status.empty), "queue both full and empty")
   `IHBF_ASSERT(a_end_on_payload, (!rsp_empty && (rsp_data.packet_end || rsp_data.datagram_end)) |-> rsp_data.run_end, "end flag on a header byte")
   `IHBF_ASSERT(a_datagram_ends_packet, (!rsp_empty && rsp_data.datagram_end) |-> rsp_data.packet_end, "datagram end without packet end")

endmodule

### rtl/ihbf_csr.sv
module ihbf_csr
   import ihbf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SOURCE_ADDR:      cfg_in.source_addr      = csr_data;
            CSR_SPLIT_THRESHOLD:  cfg_in.split_threshold  = csr_data[15:0];
            CSR_FRAGMENT_PAYLOAD: cfg_in.fragment_payload = csr_data[15:0];
            CSR_TIME_TO_LIVE:     cfg_in.time_to_live     = csr_data[7:0];
            CSR_UPPER_PROTOCOL:   cfg_in.upper_protocol   = csr_data[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_addr      <= 32'd0;
         cfg_ff.split_threshold  <= 16'd30;
         cfg_ff.fragment_payload <= 16'd24;
         cfg_ff.time_to_live     <= 8'd1;
         cfg_ff.upper_protocol   <= 8'd6;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/ihbf_front.sv
module ihbf_front
   import ihbf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    accept,
   input  req_type req,
   output job_type job
);

   logic [15:0] bytes_done_ff, bytes_done_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] frag_left_ff, frag_left_in;
   logic [15:0] id_ff, id_in;
   logic [31:0] dest_ff, dest_in;

   logic        first;
   logic [15:0] remain;
   logic [15:0] frag_left;
   logic [31:0] dest;
   logic [15:0] fp;
   logic        split;
   logic [15:0] plen;
   logic [15:0] cur_left;
   logic        hdr;

   always_comb begin
      first     = (bytes_done_ff == 16'd0);
      remain    = first ? ((req.payload_length == 16'd0) ? 16'd1 : req.payload_length)
                        : remain_ff;
      frag_left = first ? 16'd0 : frag_left_ff;
      dest      = first ? req.dest_addr : dest_ff;
      hdr       = (frag_left == 16'd0);
      fp        = (cfg.fragment_payload == 16'd0) ? 16'd1 : cfg.fragment_payload;
      split     = (remain > cfg.split_threshold) && (fp < remain);
      plen      = split ? fp : remain;
      cur_left  = hdr ? plen : frag_left;

      job.data_byte = req.data_byte;
      job.hdr       = hdr;
      job.total_len = plen + 16'd20;
      job.id        = id_ff;
      job.flags_off = (split ? MF_BIT : 16'd0) | bytes_done_ff;
      job.dest      = dest;
      job.pend      = (cur_left == 16'd1);
      job.dend      = (remain == 16'd1);

      bytes_done_in = bytes_done_ff;
      remain_in     = remain_ff;
      frag_left_in  = frag_left_ff;
      id_in         = id_ff;
      dest_in       = dest_ff;
      if (accept) begin
         dest_in = dest;
         if (job.dend) begin
            bytes_done_in = 16'd0;
            frag_left_in  = 16'd0;
            remain_in     = 16'd0;
            id_in         = id_ff + 16'd1;
         end else begin
            bytes_done_in = bytes_done_ff + 16'd1;
            remain_in     = remain - 16'd1;
            frag_left_in  = cur_left - 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_done_ff <= 16'd0;
         remain_ff     <= 16'd0;
         frag_left_ff  <= 16'd0;
         id_ff         <= 16'd1;
         dest_ff       <= 32'd0;
      end else begin
         bytes_done_ff <= bytes_done_in;
         remain_ff     <= remain_in;
         frag_left_ff  <= frag_left_in;
         id_ff         <= id_in;
         dest_ff       <= dest_in;
      end
   end

endmodule

### rtl/ihbf_queue.sv
module ihbf_queue
   import ihbf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_data,
   input  logic         pop,
   output job_type      pop_data,
   output q_status_type status
);

   job_type             slot_ff [QDEPTH];
   logic [QIDX_W-1:0]   wr_ff, wr_in;
   logic [QIDX_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   always_comb begin
      status.full  = (cnt_ff == QCNT_W'(QDEPTH));
      status.empty = (cnt_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_in        = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in        = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in       = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      pop_data     = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/ihbf_back.sv
module ihbf_back
   import ihbf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_empty,
   input  job_type q_data,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   job_type          cur_ff, cur_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      acc_ff, acc_in;
   rsp_type          out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   hdr_bytes_type    hb;
   hdr_words_type    hw;
   logic [15:0]      word;
   logic [16:0]      sum;
   logic [7:0]       hbyte;
   logic             out_ready;
   logic             step;
   logic             in_hdr;
   logic             done;
   logic             load;

   always_comb begin
      hb        = hdr_build(cur_ff, cfg);
      hw        = hb;
      word      = hw[WSEL_W'(HDR_WORDS - 1) - idx_ff[WSEL_W-1:0]];
      sum       = {1'b0, acc_ff} + {1'b0, word};
      out_ready = !out_valid_ff || rsp_pop;
      step      = cur_valid_ff && out_ready;
      in_hdr    = cur_ff.hdr && (idx_ff != IDX_W'(HDR_BYTES));
      done      = step && !in_hdr;
      load      = (!cur_valid_ff || done) && !q_empty;
      q_pop     = load;

      if (idx_ff == CSUM_HI) begin
         hbyte = ~acc_ff[15:8];
      end else if (idx_ff == CSUM_LO) begin
         hbyte = ~acc_ff[7:0];
      end else begin
         hbyte = hb[IDX_W'(HDR_BYTES - 1) - idx_ff];
      end

      cur_in       = load ? q_data : cur_ff;
      cur_valid_in = load ? 1'b1 : (done ? 1'b0 : cur_valid_ff);
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      if (load) begin
         idx_in = '0;
         acc_in = 16'd0;
      end else if (step && in_hdr) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff < IDX_W'(HDR_WORDS)) begin
            acc_in = sum[15:0] + 16'(sum[16]);
         end
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (step) begin
         out_valid_in        = 1'b1;
         out_in.out_byte     = in_hdr ? hbyte : cur_ff.data_byte;
         out_in.packet_end   = !in_hdr && cur_ff.pend;
         out_in.datagram_end = !in_hdr && cur_ff.dend;
         out_in.run_end      = !in_hdr;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      acc_ff <= acc_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### dv/frag_check_pkg.sv
`timescale 1ns / 100ps

package frag_check_pkg;
   import ihbf_pkg::*;

   class fragment_scoreboard;
      cfg_type     regs;
      logic [15:0] dgram_id;
      logic [15:0] bytes_sent;
      logic [15:0] frag_left;
      logic [15:0] dgram_len;
      logic [31:0] dgram_dest;
      rsp_type     expected_bytes[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned datagrams;
      int unsigned fragments;

      function new();
         regs.source_addr      = 32'h0;
         regs.split_threshold  = 16'd30;
         regs.fragment_payload = 16'd24;
         regs.time_to_live     = 8'd1;
         regs.upper_protocol   = 8'd6;
         dgram_id   = 16'd1;
         bytes_sent = 16'd0;
         frag_left  = 16'd0;
         dgram_len  = 16'd0;
         dgram_dest = 32'h0;
         errors     = 0;
         checked    = 0;
         datagrams  = 0;
         fragments  = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
         case (idx)
            CSR_SOURCE_ADDR:      regs.source_addr      = val;
            CSR_SPLIT_THRESHOLD:  regs.split_threshold  = val[15:0];
            CSR_FRAGMENT_PAYLOAD: regs.fragment_payload = val[15:0];
            CSR_TIME_TO_LIVE:     regs.time_to_live     = val[7:0];
            CSR_UPPER_PROTOCOL:   regs.upper_protocol   = val[7:0];
            default: ;
         endcase
      endfunction

      function logic [15:0] header_checksum(logic [159:0] hdr);
         logic [31:0] acc;
         int w;
         acc = 32'h0;
         for (w = 0; w < 10; w++) begin
            acc = acc + {16'h0, hdr[159 - 16 * w -: 16]};
            if (acc[31:16] != 16'h0) begin
               acc = {16'h0, acc[15:0]} + 32'd1;
            end
         end
         return ~acc[15:0];
      endfunction

      // build the packet bytes that one payload transaction causes
      function void accept_payload(req_type item);
         int unsigned  remaining;
         int unsigned  plen;
         int unsigned  frag_size;
         logic [15:0]  more;
         logic [15:0]  total_len;
         logic [15:0]  flags_off;
         logic [159:0] hdr;
         int           i;
         rsp_type      b;
         if (bytes_sent == 16'd0) begin
            dgram_len  = (item.payload_length == 16'd0) ? 16'd1 : item.payload_length;
            dgram_dest = item.dest_addr;
            frag_left  = 16'd0;
         end
         if (frag_left == 16'd0) begin
            remaining = int'(dgram_len) - int'(bytes_sent);
            plen = remaining;
            more = 16'h0;
            if (remaining > regs.split_threshold) begin
               frag_size = (regs.fragment_payload == 16'd0) ? 1 : regs.fragment_payload;
               if (frag_size < remaining) begin
                  plen = frag_size;
                  more = MF_BIT;
               end
            end
            total_len = 16'(plen + 20);
            flags_off = more | bytes_sent;
            hdr = {VERSION_IHL, 8'h00, total_len, dgram_id, flags_off, regs.time_to_live,
                   regs.upper_protocol, 16'h0000, regs.source_addr, dgram_dest};
            hdr[79:64] = header_checksum(hdr);
            for (i = 0; i < 20; i++) begin
               b.out_byte     = hdr[159 - 8 * i -: 8];
               b.packet_end   = 1'b0;
               b.datagram_end = 1'b0;
               b.run_end      = 1'b0;
               expected_bytes.push_back(b);
            end
            frag_left = 16'(plen);
            fragments++;
         end
         frag_left  = frag_left - 16'd1;
         bytes_sent = bytes_sent + 16'd1;
         b.out_byte     = item.data_byte;
         b.packet_end   = (frag_left == 16'd0);
         b.datagram_end = (bytes_sent == dgram_len);
         b.run_end      = 1'b1;
         expected_bytes.push_back(b);
         if (b.datagram_end) begin
            bytes_sent = 16'd0;
            frag_left  = 16'd0;
            dgram_id   = dgram_id + 16'd1;
            datagrams++;
         end
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 100) begin
            $display("ERROR at %0t: %s", $realtime, msg);
         end
      endtask

      task check_packet_byte(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("packet byte %02h with nothing outstanding",
                                      got.out_byte));
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("byte %0d out_byte %02h, want %02h",
                                      checked, got.out_byte, want.out_byte));
         end
         if (got.packet_end !== want.packet_end) begin
            report_mismatch($sformatf("byte %0d packet_end %b, want %b",
                                      checked, got.packet_end, want.packet_end));
         end
         if (got.datagram_end !== want.datagram_end) begin
            report_mismatch($sformatf("byte %0d datagram_end %b, want %b",
                                      checked, got.datagram_end, want.datagram_end));
         end
         if (got.run_end !== want.run_end) begin
            report_mismatch($sformatf("byte %0d run_end %b, want %b",
                                      checked, got.run_end, want.run_end));
         end
         checked++;
      endtask

      task close_out();
         if (expected_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d packet bytes never arrived",
                                      expected_bytes.size()));
         end
      endtask
   endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import ihbf_pkg::*;
   import frag_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 4_000_000;
   localparam int unsigned RANDOM_ITEMS = 100;
   localparam int unsigned CSR_UNMAPPED = int'(CSR_UPPER_PROTOCOL) + 1;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   logic                   req_full;
   req_type                req_data  = '0;
   logic                   rsp_empty;
   logic                   rsp_pop   = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_data  = '0;

   fragment_scoreboard board;
   int unsigned        cycles     = 0;
   int unsigned        items_sent = 0;
   bit                 quiet_tx   = 1'b0;
   bit                 quiet_rx   = 1'b0;

   ipv4_header_build_and_fragment u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int unsigned pick_gap(bit quiet);
      if (quiet) begin
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   task automatic push_payload(req_type item);
      int unsigned gap;
      if ($urandom_range(0, 15) == 0) begin
         quiet_tx = !quiet_tx;
      end
      gap = pick_gap(quiet_tx);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.accept_payload(item);
      items_sent++;
      @(negedge clock);
   endtask

   // first transaction carries length and destination, the rest carry noise there
   task automatic send_datagram(logic [15:0] len, logic [31:0] dest, logic [7:0] first_data);
      int unsigned count;
      int unsigned k;
      req_type     item;
      count = (len == 16'd0) ? 1 : len;
      item.data_byte      = first_data;
      item.payload_length = len;
      item.dest_addr      = dest;
      push_payload(item);
      for (k = 1; k < count; k++) begin
         item.data_byte      = 8'($urandom);
         item.payload_length = 16'($urandom);
         item.dest_addr      = $urandom;
         push_payload(item);
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      board.write_reg(idx, val);
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // drop push, wait for every outstanding byte, then hold for the back end
   task automatic settle(int unsigned hold);
      req_push <= 1'b0;
      while (board.expected_bytes.size() != 0) @(negedge clock);
      repeat (hold) @(negedge clock);
   endtask

   task automatic random_config();
      logic [31:0] val;
      write_csr(CSR_SOURCE_ADDR, $urandom);
      val = $urandom;
      case ($urandom_range(0, 5))
         0: val[15:0] = 16'($urandom_range(0, 1));
         1: val[15:0] = 16'd65515;
         2: val[15:0] = 16'hffff;
         default: val[15:0] = 16'($urandom_range(2, 30));
      endcase
      write_csr(CSR_SPLIT_THRESHOLD, val);
      val = $urandom;
      case ($urandom_range(0, 5))
         0: val[15:0] = 16'd0;
         1: val[15:0] = 16'd65515;
         2: val[15:0] = 16'd1;
         default: val[15:0] = 16'($urandom_range(2, 20));
      endcase
      write_csr(CSR_FRAGMENT_PAYLOAD, val);
      write_csr(CSR_TIME_TO_LIVE, $urandom);
      write_csr(CSR_UPPER_PROTOCOL, $urandom);
      if ($urandom_range(0, 2) == 0) begin
         val = $urandom_range(CSR_UNMAPPED, 2 ** CSR_INDEX_W - 1);
         write_csr(val[CSR_INDEX_W-1:0], $urandom);
      end
   endtask

   initial begin : drain
      int unsigned gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            quiet_rx = !quiet_rx;
         end
         gap = pick_gap(quiet_rx);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         board.check_packet_byte(rsp_data);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int unsigned directed_items;
      int unsigned len;
      int unsigned n;
      board = new();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset register values, zero length, field extremes
      send_datagram(16'd0, 32'hffff_ffff, 8'h00);
      send_datagram(16'd2, 32'h0000_0000, 8'hff);
      settle(25);

      write_csr(CSR_SOURCE_ADDR, 32'hffff_ffff);
      write_csr(CSR_SPLIT_THRESHOLD, 32'd3);
      write_csr(CSR_FRAGMENT_PAYLOAD, 32'd2);
      write_csr(CSR_TIME_TO_LIVE, 32'd255);
      write_csr(CSR_UPPER_PROTOCOL, 32'd255);
      for (int idx = CSR_UNMAPPED; idx < 2 ** CSR_INDEX_W; idx++) begin
         write_csr(idx[CSR_INDEX_W-1:0], $urandom);
      end
      send_datagram(16'd5, $urandom, 8'($urandom));
      settle(25);

      // zero fragment size taken as one
      write_csr(CSR_SOURCE_ADDR, 32'h0);
      write_csr(CSR_SPLIT_THRESHOLD, 32'd1);
      write_csr(CSR_FRAGMENT_PAYLOAD, 32'd0);
      write_csr(CSR_TIME_TO_LIVE, 32'd0);
      write_csr(CSR_UPPER_PROTOCOL, 32'd0);
      send_datagram(16'd3, $urandom, 8'($urandom));
      settle(25);

      // fragment size beyond what remains
      write_csr(CSR_SPLIT_THRESHOLD, 32'd2);
      write_csr(CSR_FRAGMENT_PAYLOAD, 32'd10);
      send_datagram(16'd5, $urandom, 8'($urandom));
      directed_items = items_sent;

      while (items_sent < directed_items + RANDOM_ITEMS) begin
         settle(25);
         random_config();
         n = $urandom_range(3, 8);
         repeat (n) begin
            if (items_sent < directed_items + RANDOM_ITEMS) begin
               case ($urandom_range(0, 9))
                  0: len = 0;
                  1: len = 1;
                  default: len = $urandom_range(2, 40);
               endcase
               send_datagram(len[15:0], $urandom, 8'($urandom));
            end
         end
      end

      settle(40);
      board.close_out();
      $display("%0d datagrams in %0d fragments: %0d payload bytes in, %0d packet bytes checked",
               board.datagrams, board.fragments, items_sent, board.checked);
      $display("settings: reset values, register extremes, unmapped writes, random phases");
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
